// ===== hdl/bsms_pkg.sv =====
// Package for the block split mean statistics block.
// Holds field widths, register indexes and sequencer state codes.
// No dependencies.
`default_nettype none

package bsms_pkg;

	// payload field widths
	localparam int PIX_W = 8;
	localparam int IDX_W = 2;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int TOP_W      = 5;
	localparam int LEFT_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT = 1'd1;

	localparam logic [TOP_W-1:0]  WINDOW_TOP_RST  = 5'd6;
	localparam logic [LEFT_W-1:0] WINDOW_LEFT_RST = 3'd3;

	// block arithmetic: 16 pixels per block
	localparam int BLK_PIX  = 16;
	localparam int K_W      = 5;   // holds 0..16
	localparam int SUM_W    = 12;  // 16 * 255
	localparam int CNT_W    = 5;   // 0..16
	localparam int STEP_W   = 4;   // divider steps 0..SUM_W-1

	// sequencer states
	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] S_IDLE = 3'd0;
	localparam logic [ST_W-1:0] S_SUM  = 3'd1;
	localparam logic [ST_W-1:0] S_CLS  = 3'd2;
	localparam logic [ST_W-1:0] S_LOAD = 3'd3;
	localparam logic [ST_W-1:0] S_DIV  = 3'd4;
	localparam logic [ST_W-1:0] S_EMIT = 3'd5;

endpackage

`default_nettype wire

// ===== hdl/bsms_pix_if.sv =====
// Pixel input channel: valid/ready plus pixel and image_end.
// Depends on bsms_pkg.
`default_nettype none

interface bsms_pix_if;
	logic                       valid;
	logic                       ready;
	logic [bsms_pkg::PIX_W-1:0] pixel;
	logic                       image_end;

	modport source (output valid, output pixel, output image_end, input ready);
	modport sink   (input valid, input pixel, input image_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/bsms_res_if.sv =====
// Result output channel: valid/ready plus one block's statistics.
// Depends on bsms_pkg.
`default_nettype none

interface bsms_res_if;
	logic                       valid;
	logic                       ready;
	logic [bsms_pkg::IDX_W-1:0] block_index;
	logic [bsms_pkg::PIX_W-1:0] block_mean;
	logic [bsms_pkg::PIX_W-1:0] bright_mean;
	logic [bsms_pkg::PIX_W-1:0] dark_mean;
	logic                       last_block;

	modport source (output valid, output block_index, output block_mean,
		output bright_mean, output dark_mean, output last_block, input ready);
	modport sink   (input valid, input block_index, input block_mean,
		input bright_mean, input dark_mean, input last_block, output ready);
endinterface

`default_nettype wire

// ===== hdl/block_split_mean_stats_top.sv =====
// Pixels stream in one beat per cycle while the block is idle; each pixel that
// lands inside the 4 x (4*BLOCK_COUNT) window is written to an internal RAM.
// The beat carrying image_end starts the statistics pass, during which pix.ready
// is low. Per block, the pass sums the 16 pixels through the single RAM read port,
// splits them against the mean, runs two divisions of one load step and 12
// restoring steps each on one shared divider (the load step alone when a group is
// empty), and emits the result, waiting there while the output is stalled.
// The pass holds input until the result of the last block is emitted.
// There is no clearing pass; window entries never written read as junk.
// Depends on bsms_pkg, bsms_pix_if, bsms_res_if.
`default_nettype none

module block_split_mean_stats_top #(
	parameter int IMAGE_WIDTH  = 18,
	parameter int IMAGE_HEIGHT = 20,
	parameter int BLOCK_COUNT  = 3
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	bsms_pix_if.sink                            pix,
	bsms_res_if.source                          res,
	input  wire logic                           cfg_we,
	input  wire logic [bsms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bsms_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bsms_pkg::*;

	localparam int WIN_COLS = 4 * BLOCK_COUNT;
	localparam int WIN_SIZE = BLK_PIX * BLOCK_COUNT;
	localparam int AW       = $clog2(WIN_SIZE);
	localparam int COL_W    = $clog2(IMAGE_WIDTH);
	localparam int ROW_W    = $clog2(IMAGE_HEIGHT + 1);
	localparam int BLK_W    = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
	localparam int MAX_PW   = (ROW_W > COL_W) ? ROW_W : COL_W;
	localparam int CMP_W    = ((MAX_PW > TOP_W) ? MAX_PW : TOP_W) + 1;

	// configuration
	logic [TOP_W-1:0]  win_top_q;
	logic [LEFT_W-1:0] win_left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_top_q  <= WINDOW_TOP_RST;
			win_left_q <= WINDOW_LEFT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_WINDOW_TOP)
				win_top_q <= cfg_data[TOP_W-1:0];
			else if (cfg_index == REG_WINDOW_LEFT)
				win_left_q <= cfg_data[LEFT_W-1:0];
		end
	end

	logic [ST_W-1:0] state_q;
	logic            in_acc;

	assign pix.ready = (state_q == S_IDLE);
	assign in_acc    = pix.valid && pix.ready;

	// raster position
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (pix.image_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_q < ROW_W'(IMAGE_HEIGHT)) begin
				if (col_q == COL_W'(IMAGE_WIDTH - 1)) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// window placement of the incoming pixel
	logic [CMP_W-1:0] row_x, col_x, top_x, left_x, rel_row, rel_col;
	logic             in_win;
	logic [AW-1:0]    wr_addr;

	always_comb begin
		row_x   = CMP_W'(row_q);
		col_x   = CMP_W'(col_q);
		top_x   = CMP_W'(win_top_q);
		left_x  = CMP_W'(win_left_q);
		rel_row = row_x - top_x;
		rel_col = col_x - left_x;
		in_win  = (row_q < ROW_W'(IMAGE_HEIGHT)) && (row_x >= top_x) && (col_x >= left_x)
			&& (rel_row < CMP_W'(4)) && (rel_col < CMP_W'(WIN_COLS));
		wr_addr = AW'(int'(rel_row[1:0]) * WIN_COLS + int'(rel_col));
	end

	// window RAM: one write port, one registered read port
	logic [PIX_W-1:0] win_mem [WIN_SIZE];
	logic [AW-1:0]    rd_addr;
	logic [PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (in_acc && in_win)
			win_mem[wr_addr] <= pix.pixel;
	end

	always_ff @(posedge clk) begin
		rd_data_q <= win_mem[rd_addr];
	end

	// sequencer registers
	logic [BLK_W-1:0]  blk_q;
	logic [K_W-1:0]    k_q;
	logic              rd_vld_q;
	logic [SUM_W-1:0]  sum_q, sum_hi_q, sum_lo_q;
	logic [CNT_W-1:0]  cnt_hi_q, cnt_lo_q;
	logic              div_sel_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q, dvs_q;
	logic [STEP_W-1:0] step_q;
	logic [PIX_W-1:0]  bright_q, dark_q;
	logic              out_vld_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [PIX_W-1:0]  out_mean_q, out_bright_q, out_dark_q;
	logic              out_last_q;

	logic [PIX_W-1:0]  mean;
	logic              issue;
	logic              blk_last;
	logic [CNT_W:0]    trial;
	logic              q_bit;
	logic [SUM_W-1:0]  quo_nx;
	logic              out_free;

	always_comb begin
		mean     = sum_q[SUM_W-1:SUM_W-PIX_W];
		issue    = (k_q < K_W'(BLK_PIX));
		rd_addr  = AW'(int'(k_q[3:2]) * WIN_COLS + int'(blk_q) * 4 + int'(k_q[1:0]));
		blk_last = (blk_q == BLK_W'(BLOCK_COUNT - 1));
		trial    = {rem_q, quo_q[SUM_W-1]};
		q_bit    = (trial >= {1'b0, dvs_q});
		quo_nx   = {quo_q[SUM_W-2:0], q_bit};
		out_free = !out_vld_q || res.ready;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			blk_q     <= '0;
			k_q       <= '0;
			rd_vld_q  <= 1'b0;
			div_sel_q <= 1'b0;
			step_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= 1'b0;
			if (out_vld_q && res.ready)
				out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc && pix.image_end) begin
						state_q <= S_SUM;
						blk_q   <= '0;
						k_q     <= '0;
					end
				end
				S_SUM, S_CLS: begin
					if (issue) begin
						k_q      <= k_q + 1'b1;
						rd_vld_q <= 1'b1;
					end else if (rd_vld_q) begin
						k_q <= '0;
						if (state_q == S_SUM) begin
							state_q <= S_CLS;
						end else begin
							state_q   <= S_LOAD;
							div_sel_q <= 1'b0;
						end
					end
				end
				S_LOAD: begin
					step_q <= '0;
					if ((div_sel_q ? cnt_lo_q : cnt_hi_q) != '0)
						state_q <= S_DIV;
					else if (div_sel_q)
						state_q <= S_EMIT;
					else
						div_sel_q <= 1'b1;
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SUM_W - 1)) begin
						if (div_sel_q) begin
							state_q <= S_EMIT;
						end else begin
							state_q   <= S_LOAD;
							div_sel_q <= 1'b1;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						if (blk_last) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SUM;
							blk_q   <= blk_q + 1'b1;
							k_q     <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: accumulators, shared divider, output register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				sum_q    <= '0;
				sum_hi_q <= '0;
				sum_lo_q <= '0;
				cnt_hi_q <= '0;
				cnt_lo_q <= '0;
			end
			S_EMIT: begin
				// block totals stay until the result is latched
				if (out_free) begin
					sum_q    <= '0;
					sum_hi_q <= '0;
					sum_lo_q <= '0;
					cnt_hi_q <= '0;
					cnt_lo_q <= '0;
				end
			end
			S_SUM: begin
				if (rd_vld_q)
					sum_q <= sum_q + SUM_W'(rd_data_q);
			end
			S_CLS: begin
				if (rd_vld_q) begin
					if (rd_data_q > mean) begin
						sum_hi_q <= sum_hi_q + SUM_W'(rd_data_q);
						cnt_hi_q <= cnt_hi_q + 1'b1;
					end else if (rd_data_q < mean) begin
						sum_lo_q <= sum_lo_q + SUM_W'(rd_data_q);
						cnt_lo_q <= cnt_lo_q + 1'b1;
					end
				end
			end
			S_LOAD: begin
				quo_q <= div_sel_q ? sum_lo_q : sum_hi_q;
				dvs_q <= div_sel_q ? cnt_lo_q : cnt_hi_q;
				rem_q <= '0;
				// empty group reports the block mean
				if (div_sel_q)
					dark_q <= mean;
				else
					bright_q <= mean;
			end
			S_DIV: begin
				quo_q <= quo_nx;
				rem_q <= q_bit ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
				if (step_q == STEP_W'(SUM_W - 1)) begin
					if (div_sel_q)
						dark_q <= quo_nx[PIX_W-1:0];
					else
						bright_q <= quo_nx[PIX_W-1:0];
				end
			end
			default: ;
		endcase
		if (state_q == S_EMIT && out_free) begin
			out_idx_q    <= IDX_W'(blk_q);
			out_mean_q   <= mean;
			out_bright_q <= bright_q;
			out_dark_q   <= dark_q;
			out_last_q   <= blk_last;
		end
	end

	assign res.valid       = out_vld_q;
	assign res.block_index = out_idx_q;
	assign res.block_mean  = out_mean_q;
	assign res.bright_mean = out_bright_q;
	assign res.dark_mean   = out_dark_q;
	assign res.last_block  = out_last_q;

	// checks
	a_start_block0: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && pix.image_end) |=> (state_q == S_SUM && blk_q == '0 && k_q == '0))
		else $error("statistics pass did not start at block zero");

	a_group_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (bright_q >= mean && dark_q <= mean))
		else $error("bright/dark means out of order around block mean");

	a_group_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> ((CNT_W + 1)'(cnt_hi_q) + (CNT_W + 1)'(cnt_lo_q)
			<= (CNT_W + 1)'(BLK_PIX)))
		else $error("group counts exceed block size");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < dvs_q))
		else $error("divider remainder not below divisor");

	a_no_input_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> !(in_acc && $past(state_q) == S_EMIT && !$past(blk_last)))
		else $error("pixel accepted in the middle of a statistics pass");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for block_split_mean_stats_top: streams grey images, predicts the per-block
// mean / bright / dark statistics in-house and checks every result beat in order.
// Depends on bsms_pkg, bsms_pix_if, bsms_res_if and the block itself.

module testbench;
	import bsms_pkg::*;

	localparam int IMG_W        = 18;
	localparam int IMG_H        = 20;
	localparam int BLOCKS       = 3;
	localparam int WIN_COLS     = 4 * BLOCKS;
	localparam int WIN_PIX      = 16 * BLOCKS;
	localparam int SETTLE_CYC   = 200;   // settle wait after the last pending result
	localparam int MIN_BEATS    = 480;
	localparam int PHASE1_AT    = 360;   // beats before the receiver-heavy phase
	localparam int PHASE2_AT    = 420;   // beats before the back-to-back phase
	localparam int RAND_LEN_MAX = 40;

	typedef enum logic [1:0] {PAT_FLAT, PAT_CHECK, PAT_RAMP, PAT_RAND} pat_t;

	typedef struct {
		logic [IDX_W-1:0] index;
		logic [PIX_W-1:0] mean;
		logic [PIX_W-1:0] bright;
		logic [PIX_W-1:0] dark;
		logic             last;
	} stats_t;

	// one row of the directed plan: optional window move, then a run of pixels
	typedef struct {
		bit              set_cfg;
		logic [TOP_W-1:0]  top;
		logic [LEFT_W-1:0] left;
		int              count;
		pat_t            pat;
		logic [7:0]      a;
		logic [7:0]      b;
		bit              ends;
		bit              fixed;
		logic [7:0]      x_mean;
		logic [7:0]      x_bright;
		logic [7:0]      x_dark;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bsms_pix_if pix_ch ();
	bsms_res_if res_ch ();

	block_split_mean_stats_top #(
		.IMAGE_WIDTH (IMG_W),
		.IMAGE_HEIGHT(IMG_H),
		.BLOCK_COUNT (BLOCKS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state: window store, raster position, window registers
	logic [7:0]        win_pix [WIN_PIX];
	int                pos_col, pos_row;
	logic [TOP_W-1:0]  win_top;
	logic [LEFT_W-1:0] win_left;

	stats_t stats_due [$];
	int errors, results_seen, beats, images, window_writes;
	int send_idle_pct, recv_idle_pct;

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= 40)
			$display("mismatch: %s got %0d want %0d (result %0d)", what, got, want, results_seen);
	endtask

	// store the pixel if it lands in the window, then step the raster position
	task automatic window_take(input logic [7:0] p, input logic last_px);
		int r, c;
		if (pos_row < IMG_H && pos_row >= win_top && pos_col >= win_left) begin
			r = pos_row - win_top;
			c = pos_col - win_left;
			if (r < 4 && c < WIN_COLS)
				win_pix[r * WIN_COLS + c] = p;
		end
		if (pos_row < IMG_H) begin
			pos_col++;
			if (pos_col >= IMG_W) begin
				pos_col = 0;
				pos_row++;
			end
		end
		if (last_px) begin
			pos_col = 0;
			pos_row = 0;
		end
	endtask

	function automatic stats_t block_stats(input int b);
		stats_t st;
		int v, sum, mean, sum_hi, cnt_hi, sum_lo, cnt_lo;
		sum = 0;
		sum_hi = 0;
		cnt_hi = 0;
		sum_lo = 0;
		cnt_lo = 0;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				sum += win_pix[r * WIN_COLS + b * 4 + c];
		mean = sum >> 4;
		// pixels equal to the mean join neither group
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				v = win_pix[r * WIN_COLS + b * 4 + c];
				if (v > mean) begin
					sum_hi += v;
					cnt_hi++;
				end else if (v < mean) begin
					sum_lo += v;
					cnt_lo++;
				end
			end
		end
		st.index  = IDX_W'(b);
		st.mean   = 8'(mean);
		st.bright = 8'(cnt_hi != 0 ? sum_hi / cnt_hi : mean);
		st.dark   = 8'(cnt_lo != 0 ? sum_lo / cnt_lo : mean);
		st.last   = (b == BLOCKS - 1);
		return st;
	endfunction

	// present one pixel beat, wait for acceptance, then update the prediction
	task automatic send_beat(input logic [7:0] p, input logic last_px, input bit fixed,
			input logic [7:0] xm, input logic [7:0] xb, input logic [7:0] xd);
		stats_t st;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid     <= 1'b1;
		pix_ch.pixel     <= p;
		pix_ch.image_end <= last_px;
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
		beats++;
		window_take(p, last_px);
		if (last_px) begin
			images++;
			for (int b = 0; b < BLOCKS; b++) begin
				if (fixed) begin
					st.index  = IDX_W'(b);
					st.mean   = xm;
					st.bright = xb;
					st.dark   = xd;
					st.last   = (b == BLOCKS - 1);
				end else begin
					st = block_stats(b);
				end
				stats_due.push_back(st);
			end
		end
	endtask

	// drop valid, wait for every pending result, then let the pass wind down
	task automatic settle();
		pix_ch.valid <= 1'b0;
		while (stats_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_window(input logic [TOP_W-1:0] top, input logic [LEFT_W-1:0] left);
		cfg_we    <= 1'b1;
		cfg_index <= REG_WINDOW_TOP;
		cfg_data  <= CFG_DATA_W'(top);
		@(posedge clk);
		cfg_index <= REG_WINDOW_LEFT;
		cfg_data  <= CFG_DATA_W'(left);
		@(posedge clk);
		cfg_we   <= 1'b0;
		win_top  = top;
		win_left = left;
		window_writes++;
	endtask

	// mostly row 0, which short images reach, now and then a lower or off-image row
	function automatic logic [TOP_W-1:0] pick_top();
		case ($urandom_range(0, 7))
			0:       return TOP_W'($urandom_range(17, 31));
			1, 2:    return TOP_W'($urandom_range(1, 16));
			default: return TOP_W'(0);
		endcase
	endfunction

	function automatic logic [LEFT_W-1:0] pick_left();
		if ($urandom_range(0, 7) == 0)
			return LEFT_W'(7);
		return LEFT_W'($urandom_range(0, 6));
	endfunction

	function automatic logic [7:0] row_pixel(input row_t rw, input int n);
		case (rw.pat)
			PAT_FLAT:  return (n < IMG_W * IMG_H) ? rw.a : rw.b;
			PAT_CHECK: return (((n / IMG_W) + (n % IMG_W)) % 2 != 0) ? rw.b : rw.a;
			PAT_RAMP:  return 8'(n + rw.a);
			default:   return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// pixel styles: noise, two-level glyph, narrow band (many ties), flat with specks
	function automatic logic [7:0] styled_pixel(input int style, input logic [7:0] base);
		case (style)
			0: return 8'($urandom_range(0, 255));
			1: return $urandom_range(0, 1) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(200, 255));
			2: return 8'(base + $urandom_range(0, 2));
			default: return ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : base;
		endcase
	endfunction

	// receiver stalls
	initial begin : result_ready
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin : result_check
		stats_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (stats_due.size() == 0) begin
				report_mismatch("result beat with nothing pending", res_ch.block_index, 0);
			end else begin
				want = stats_due.pop_front();
				if (res_ch.block_index !== want.index)
					report_mismatch("block_index", res_ch.block_index, want.index);
				if (res_ch.block_mean !== want.mean)
					report_mismatch("block_mean", res_ch.block_mean, want.mean);
				if (res_ch.bright_mean !== want.bright)
					report_mismatch("bright_mean", res_ch.bright_mean, want.bright);
				if (res_ch.dark_mean !== want.dark)
					report_mismatch("dark_mean", res_ch.dark_mean, want.dark);
				if (res_ch.last_block !== want.last)
					report_mismatch("last_block", res_ch.last_block, want.last);
			end
		end
	end

	// hang guard
	initial begin : watchdog
		#7_200_000;
		$display("testbench failed");
		$finish;
	end

	initial begin : stimulus
		row_t plan [0:8];
		int n, len, mid_at, style, phase;
		logic [7:0] base;

		arst_n           = 1'b0;
		pix_ch.valid     = 1'b0;
		pix_ch.pixel     = '0;
		pix_ch.image_end = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = REG_WINDOW_TOP;
		cfg_data         = '0;
		send_idle_pct    = 31;
		recv_idle_pct    = 58;
		phase            = 0;
		pos_col          = 0;
		pos_row          = 0;
		win_top          = WINDOW_TOP_RST;
		win_left         = WINDOW_LEFT_RST;
		foreach (win_pix[i])
			win_pix[i] = '0;

		// first row fills the whole window, so no later image reads an unwritten entry
		plan[0] = '{1, 5'd0,  3'd0, 66, PAT_FLAT,  8'd0,   8'd0,   1, 1, 8'd0,   8'd0,   8'd0};
		plan[1] = '{0, 5'd0,  3'd0, 66, PAT_FLAT,  8'd255, 8'd255, 1, 1, 8'd255, 8'd255, 8'd255};
		// half black, half white in every block
		plan[2] = '{1, 5'd0,  3'd6, 72, PAT_CHECK, 8'd0,   8'd255, 1, 1, 8'd127, 8'd255, 8'd0};
		// image ends on its first pixel, window untouched
		plan[3] = '{0, 5'd0,  3'd6, 1,  PAT_FLAT,  8'd77,  8'd77,  1, 1, 8'd127, 8'd255, 8'd0};
		// early end inside the window rows
		plan[4] = '{1, 5'd1,  3'd2, 40, PAT_RAMP,  8'd0,   8'd0,   1, 0, 8'd0,   8'd0,   8'd0};
		// window moves in the middle of an image
		plan[5] = '{1, 5'd0,  3'd1, 30, PAT_RAND,  8'd0,   8'd0,   0, 0, 8'd0,   8'd0,   8'd0};
		plan[6] = '{1, 5'd2,  3'd5, 30, PAT_RAND,  8'd0,   8'd0,   1, 0, 8'd0,   8'd0,   8'd0};
		// window wholly, then partly, off the image
		plan[7] = '{1, 5'd31, 3'd7, 5,  PAT_RAND,  8'd0,   8'd0,   1, 0, 8'd0,   8'd0,   8'd0};
		plan[8] = '{1, 5'd0,  3'd7, 40, PAT_RAMP,  8'd128, 8'd0,   1, 0, 8'd0,   8'd0,   8'd0};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan
		n = 0;
		foreach (plan[i]) begin
			if (plan[i].set_cfg) begin
				settle();
				set_window(plan[i].top, plan[i].left);
			end
			for (int k = 0; k < plan[i].count; k++) begin
				send_beat(row_pixel(plan[i], n), plan[i].ends && k == plan[i].count - 1,
					plan[i].fixed, plan[i].x_mean, plan[i].x_bright, plan[i].x_dark);
				n++;
			end
			if (plan[i].ends)
				n = 0;
		end

		// random short images until the beat budget is spent
		while (beats < MIN_BEATS) begin
			if (phase == 0 && beats >= PHASE1_AT) begin
				settle();
				send_idle_pct = 58;
				recv_idle_pct = 31;
				phase = 1;
			end else if (phase == 1 && beats >= PHASE2_AT) begin
				settle();
				send_idle_pct = 0;
				recv_idle_pct = 0;
				phase = 2;
			end
			if ($urandom_range(0, 3) == 0) begin
				settle();
				set_window(pick_top(), pick_left());
			end
			len    = $urandom_range(1, RAND_LEN_MAX);
			style  = $urandom_range(0, 3);
			base   = 8'($urandom_range(0, 255));
			mid_at = (len > 1 && $urandom_range(0, 99) < 15) ? $urandom_range(1, len - 1) : -1;
			for (int k = 0; k < len; k++) begin
				if (k == mid_at) begin
					settle();
					set_window(pick_top(), pick_left());
				end
				send_beat(styled_pixel(style, base), k == len - 1, 0, 8'd0, 8'd0, 8'd0);
			end
		end

		settle();

		$display("run covered %0d pixel beats in %0d images, %0d block results, %0d window moves",
			beats, images, results_seen, window_writes);
		$display("idle mix: sender-heavy, receiver-heavy and back-to-back phases");
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/bsms_pkg.sv
hdl/bsms_pix_if.sv
hdl/bsms_res_if.sv
hdl/block_split_mean_stats_top.sv
verif/testbench.sv
